// ===== rtl/core/battery_level_tracker_top_assert.svh =====
// Assertion macros shared by the battery level tracker RTL.
`ifndef BATTERY_LEVEL_TRACKER_TOP_ASSERT_SVH
`define BATTERY_LEVEL_TRACKER_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising clk edge outside reset.
`define BLT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("battery_level_tracker assertion failed");

// Next-cycle implication.
`define BLT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("battery_level_tracker assertion failed");

`endif

// ===== rtl/core/blt_pkg.sv =====
// Package with shared widths, register indexes and reset values of the tracker.
`default_nettype none
package blt_pkg;

  localparam int ADC_BITS_DEF  = 10;
  localparam int FRAC_BITS_DEF = 8;

  localparam int PCT_W = 7;
  localparam int CNT_W = 9;

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY_LEVEL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_LEVEL   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_JUMP_LIMIT   = 3'd4;

  localparam logic [7:0]       SMOOTHING_RST   = 8'd4;
  localparam logic [PCT_W-1:0] COUNT_LIMIT_RST = 7'd10;
  localparam logic [PCT_W-1:0] JUMP_LIMIT_RST  = 7'd1;

endpackage
`default_nettype wire

// ===== rtl/core/blt_in_if.sv =====
// Input channel: one tick with charger flag, ADC sample and priming mark.
`default_nettype none
interface blt_in_if
  import blt_pkg::*;
#(
  parameter int ADC_BITS = ADC_BITS_DEF
) ();
  logic                valid;
  logic                ready;
  logic                charging;
  logic [ADC_BITS-1:0] sample;
  logic                priming;

  modport source (output valid, output charging, output sample, output priming,
                  input ready);
  modport sink (input valid, input charging, input sample, input priming,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/core/blt_out_if.sv =====
// Output channel: reported state, smoothed percent and corrected sample.
`default_nettype none
interface blt_out_if
  import blt_pkg::*;
#(
  parameter int ADC_BITS = ADC_BITS_DEF
) ();
  logic                       valid;
  logic                       ready;
  logic                       report;
  logic                       shown_charging;
  logic [PCT_W-1:0]           shown_percent;
  logic [PCT_W-1:0]           smoothed_percent;
  logic signed [ADC_BITS+1:0] corrected_sample;

  modport source (output valid, output report, output shown_charging,
                  output shown_percent, output smoothed_percent,
                  output corrected_sample, input ready);
  modport sink (input valid, input report, input shown_charging,
                input shown_percent, input smoothed_percent,
                input corrected_sample, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/battery_level_tracker_top.sv =====
// Top level of the battery level tracker: sequencer around one shared divider.
//
//   channel  | dir | handshake          | transaction
//   ---------+-----+--------------------+---------------------------------------
//   tick     | in  | valid/ready        | charging, sample, priming
//   status   | out | valid/ready        | report, shown_charging, shown_percent,
//            |     |                    | smoothed_percent, corrected_sample
//   cfg      | in  | cfg_we, no ready   | cfg_index, cfg_data
//
// The cost of a tick is set by two passes of the shared restoring divider, each
// producing one quotient bit a cycle over DW = max(ADC_BITS+7, FRAC_BITS+8) bits:
// one pass for the percent scaling, one for the filter step. A reading at or
// outside the levels skips the percent pass; the first tick skips the filter pass.
// tick.ready is high only while the sequencer is idle; a finished transaction
// waits in the output register, and the next tick is accepted meanwhile.
// A stalled output holds the sequencer in its last step until status drains.
// Reset (rst, synchronous) clears the control and tracking state and loads the
// register reset values; no clearing pass is needed.
`default_nettype none
`include "battery_level_tracker_top_assert.svh"
module battery_level_tracker_top
  import blt_pkg::*;
#(
  parameter int ADC_BITS  = ADC_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  blt_in_if.sink                    tick,
  blt_out_if.source                 status,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ADC_BITS-1:0]  cfg_data
);

  // Datapath widths
  localparam int COR_W  = ADC_BITS + 2;            // corrected sample, signed
  localparam int OFS_W  = ADC_BITS + 1;            // charge offset, signed
  localparam int FV_W   = FRAC_BITS + PCT_W;       // filter value, unsigned
  localparam int NUM_W  = FRAC_BITS + 9;           // filter numerator, signed
  localparam int MAG_W  = FRAC_BITS + 8;           // numerator magnitude
  localparam int PD_W   = ADC_BITS + PCT_W;        // 100 * (corrected - empty)
  localparam int DW     = (PD_W > MAG_W) ? PD_W : MAG_W;
  localparam int DVW    = (ADC_BITS > 9) ? ADC_BITS : 9;
  localparam int DCNT_W = $clog2(DW + 1);

  localparam logic [FV_W-1:0] FILT_MAX = FV_W'(PCT_FULL) << FRAC_BITS;

  // Sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_OFS   = 3'd1;  // recompute charge offset
  localparam logic [2:0] S_SCALE = 3'd2;  // correct sample, set up percent divide
  localparam logic [2:0] S_DIV1  = 3'd3;  // percent division
  localparam logic [2:0] S_FILT  = 3'd4;  // set up filter divide or first load
  localparam logic [2:0] S_DIV2  = 3'd5;  // filter step division
  localparam logic [2:0] S_UPD   = 3'd6;  // apply filter step
  localparam logic [2:0] S_FIN   = 3'd7;  // hysteresis, report, output load

  // Configuration registers
  logic [ADC_BITS-1:0] empty_level;
  logic [ADC_BITS-1:0] full_level;
  logic [7:0]          smoothing_divisor;
  logic [PCT_W-1:0]    count_limit;
  logic [PCT_W-1:0]    jump_limit;

  // Sequencer and captured tick
  logic [2:0]          state;
  logic                chg_q;
  logic [ADC_BITS-1:0] smp_q;
  logic                prime_q;

  // Tracking state
  logic                    held_charging;
  logic [PCT_W-1:0]        held_percent;
  logic signed [COR_W-1:0] last_corrected;
  logic signed [OFS_W-1:0] charge_offset;
  logic [FV_W-1:0]         filter_value;
  logic                    first_pending;
  logic signed [CNT_W-1:0] change_count;

  // Shared divider
  logic [DW-1:0]     dvd;
  logic [DVW-1:0]    rem;
  logic [DVW-1:0]    divisor;
  logic [DCNT_W-1:0] div_cnt;
  logic              neg_q;

  // Output register
  logic                    o_valid;
  logic                    o_report;
  logic                    o_shown_chg;
  logic [PCT_W-1:0]        o_shown_pct;
  logic [PCT_W-1:0]        o_smoothed;
  logic signed [COR_W-1:0] o_corr;

  assign tick.ready              = (state == S_IDLE);
  assign status.valid            = o_valid;
  assign status.report           = o_report;
  assign status.shown_charging   = o_shown_chg;
  assign status.shown_percent    = o_shown_pct;
  assign status.smoothed_percent = o_smoothed;
  assign status.corrected_sample = o_corr;

  // ---------------------------------------------------------------------
  // Offset recompute: pull the offset so the corrected level does not jump
  // when the charger is plugged or unplugged.
  // ---------------------------------------------------------------------
  logic                    held_eff;
  logic signed [COR_W-1:0] smp_s;
  logic signed [COR_W-1:0] ofs_diff;
  logic                    fix_take;
  logic signed [OFS_W-1:0] ofs_sat;
  logic signed [OFS_W-1:0] ofs_fix;

  always_comb begin
    held_eff = prime_q ? chg_q : held_charging;
    smp_s    = $signed({2'b00, smp_q});
    ofs_diff = last_corrected - smp_s;
    fix_take = chg_q ? (smp_s > last_corrected) : (smp_s < last_corrected);
    if (ofs_diff[COR_W-1] == ofs_diff[COR_W-2]) begin
      ofs_sat = ofs_diff[OFS_W-1:0];
    end else if (ofs_diff[COR_W-1]) begin
      ofs_sat = $signed({1'b1, {ADC_BITS{1'b0}}});
    end else begin
      ofs_sat = $signed({1'b0, {ADC_BITS{1'b1}}});
    end
    ofs_fix = fix_take ? ofs_sat : '0;
  end

  // ---------------------------------------------------------------------
  // Correction and percent setup. The sum cannot leave the corrected range
  // with a saturated offset, so no clamp is applied.
  // ---------------------------------------------------------------------
  logic signed [COR_W-1:0] corr;
  logic signed [COR_W-1:0] e_s;
  logic signed [COR_W-1:0] f_s;
  logic [ADC_BITS-1:0]     span;
  logic [PD_W-1:0]         scaled;

  always_comb begin
    corr   = smp_s + {charge_offset[OFS_W-1], charge_offset};
    e_s    = $signed({2'b00, empty_level});
    f_s    = $signed({2'b00, full_level});
    span   = corr[ADC_BITS-1:0] - empty_level;
    // times 100 as 64 + 32 + 4
    scaled = PD_W'({span, 6'b0}) + PD_W'({span, 5'b0}) + PD_W'({span, 2'b0});
  end

  // ---------------------------------------------------------------------
  // Restoring divider step, one quotient bit a cycle; quotient shifts into dvd.
  // ---------------------------------------------------------------------
  logic [DVW:0]   trial;
  logic           fits;
  logic [DVW:0]   trial_sub;
  logic [DVW-1:0] rem_step;
  logic [DW-1:0]  dvd_step;

  always_comb begin
    trial     = {rem, dvd[DW-1]};
    fits      = trial >= {1'b0, divisor};
    trial_sub = trial - {1'b0, divisor};
    rem_step  = fits ? trial_sub[DVW-1:0] : trial[DVW-1:0];
    dvd_step  = {dvd[DW-2:0], fits};
  end

  // ---------------------------------------------------------------------
  // Filter: step = floor((2*(target - value) + d) / (2*d)), half rounds up.
  // ---------------------------------------------------------------------
  logic [FV_W-1:0]         target;
  logic [7:0]              step_div;
  logic signed [NUM_W-1:0] diff_s;
  logic signed [NUM_W-1:0] num;
  logic                    num_neg;
  logic [NUM_W-1:0]        num_abs;
  logic [8:0]              den;
  logic                    rem_nz;
  logic [NUM_W-1:0]        qmag;
  logic [NUM_W-1:0]        qstep;
  logic [NUM_W-1:0]        fv_sum;

  always_comb begin
    target   = {dvd[PCT_W-1:0], {FRAC_BITS{1'b0}}};
    step_div = (smoothing_divisor == 8'd0) ? 8'd1 : smoothing_divisor;
    diff_s   = $signed({2'b00, target}) - $signed({2'b00, filter_value});
    num      = $signed({diff_s[NUM_W-2:0], 1'b0})
             + $signed({{(NUM_W-8){1'b0}}, step_div});
    num_neg  = num[NUM_W-1];
    num_abs  = num_neg ? -num : num;
    den      = {step_div, 1'b0};
    // negative side: -ceil(|num| / den)
    rem_nz   = (rem != '0);
    qmag     = {1'b0, dvd[MAG_W-1:0]} + {{(NUM_W-1){1'b0}}, rem_nz && neg_q};
    qstep    = neg_q ? -qmag : qmag;
    fv_sum   = {2'b00, filter_value} + qstep;
  end

  // ---------------------------------------------------------------------
  // Hysteresis on the rounded percent.
  // ---------------------------------------------------------------------
  logic [FV_W:0]           round_sum;
  logic [PCT_W-1:0]        pct;
  logic                    up;
  logic                    down;
  logic [PCT_W-1:0]        step;
  logic signed [CNT_W-1:0] step_s;
  logic signed [CNT_W-1:0] cnt_new;
  logic [CNT_W-1:0]        cnt_mag;
  logic                    over;
  logic                    rep;
  logic                    held_chg_after;
  logic [PCT_W-1:0]        held_pct_after;
  logic                    fin_go;

  always_comb begin
    round_sum = {1'b0, filter_value}
              + {{(FV_W+1-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
    pct       = round_sum[FRAC_BITS+PCT_W-1:FRAC_BITS];
    up        = pct > held_percent;
    down      = pct < held_percent;
    step      = up ? (pct - held_percent) : (held_percent - pct);
    step_s    = $signed({2'b00, step});
    if (up) begin
      cnt_new = change_count + step_s;
    end else if (down) begin
      cnt_new = change_count - step_s;
    end else begin
      cnt_new = '0;
    end
    cnt_mag = cnt_new[CNT_W-1] ? -cnt_new : cnt_new;
    over    = cnt_mag > {2'b00, count_limit};
    rep     = !prime_q &&
              ((chg_q != held_charging) ||
               (over && (step > jump_limit)) ||
               (held_charging && up && over && !cnt_new[CNT_W-1]) ||
               (!held_charging && down && over && cnt_new[CNT_W-1]));
    held_chg_after = rep ? chg_q : held_charging;
    held_pct_after = (rep || prime_q) ? pct : held_percent;
    fin_go  = (state == S_FIN) && (!o_valid || status.ready);
  end

  // ---------------------------------------------------------------------
  // Configuration writes
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      empty_level       <= '0;
      full_level        <= '1;
      smoothing_divisor <= SMOOTHING_RST;
      count_limit       <= COUNT_LIMIT_RST;
      jump_limit        <= JUMP_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_EMPTY_LEVEL: empty_level       <= cfg_data;
        REG_FULL_LEVEL:  full_level        <= cfg_data;
        REG_SMOOTHING:   smoothing_divisor <= cfg_data[7:0];
        REG_COUNT_LIMIT: count_limit       <= cfg_data[PCT_W-1:0];
        REG_JUMP_LIMIT:  jump_limit        <= cfg_data[PCT_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer, tracking state and shared divider
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      held_charging  <= 1'b0;
      held_percent   <= '0;
      last_corrected <= '0;
      charge_offset  <= '0;
      filter_value   <= '0;
      first_pending  <= 1'b1;
      change_count   <= '0;
      div_cnt        <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (tick.valid) begin
            state <= S_OFS;
          end
        end
        S_OFS: begin
          held_charging <= held_eff;
          if (chg_q != held_eff) begin
            charge_offset <= ofs_fix;
          end
          state <= S_SCALE;
        end
        S_SCALE: begin
          last_corrected <= corr;
          rem            <= '0;
          if (corr <= e_s) begin
            dvd   <= '0;
            state <= S_FILT;
          end else if (corr >= f_s) begin
            dvd   <= DW'(PCT_FULL);
            state <= S_FILT;
          end else begin
            dvd     <= DW'(scaled);
            divisor <= DVW'(full_level - empty_level);
            div_cnt <= DCNT_W'(DW);
            state   <= S_DIV1;
          end
        end
        S_DIV1, S_DIV2: begin
          dvd     <= dvd_step;
          rem     <= rem_step;
          div_cnt <= div_cnt - 1'b1;
          if (div_cnt == DCNT_W'(1)) begin
            state <= (state == S_DIV1) ? S_FILT : S_UPD;
          end
        end
        S_FILT: begin
          if (first_pending) begin
            // first sample loads the filter directly
            filter_value  <= target;
            first_pending <= 1'b0;
            state         <= S_FIN;
          end else begin
            neg_q   <= num_neg;
            dvd     <= DW'(num_abs[MAG_W-1:0]);
            rem     <= '0;
            divisor <= DVW'(den);
            div_cnt <= DCNT_W'(DW);
            state   <= S_DIV2;
          end
        end
        S_UPD: begin
          filter_value <= fv_sum[FV_W-1:0];
          state        <= S_FIN;
        end
        S_FIN: begin
          if (fin_go) begin
            held_charging <= held_chg_after;
            held_percent  <= held_pct_after;
            if (!prime_q) begin
              if (rep) begin
                change_count <= '0;
              end else if (over) begin
                // nudge the offset one step toward zero
                if (!cnt_new[CNT_W-1] && !charge_offset[OFS_W-1] &&
                    (charge_offset != '0)) begin
                  charge_offset <= charge_offset - 1'b1;
                end else if (cnt_new[CNT_W-1] && charge_offset[OFS_W-1]) begin
                  charge_offset <= charge_offset + 1'b1;
                end
                change_count <= '0;
              end else begin
                change_count <= cnt_new;
              end
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Capture the tick payload on acceptance
  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      chg_q   <= tick.charging;
      smp_q   <= tick.sample;
      prime_q <= tick.priming;
    end
  end

  // Output register: load on the last step, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (fin_go) begin
      o_valid <= 1'b1;
    end else if (status.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      o_report    <= rep;
      o_shown_chg <= held_chg_after;
      o_shown_pct <= held_pct_after;
      o_smoothed  <= pct;
      o_corr      <= last_corrected;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `BLT_ASSERT_IMPL(a_filter_range, 1'b1, filter_value <= FILT_MAX)
  `BLT_ASSERT_NEXT(a_report_clears_count, fin_go && rep, change_count == '0)
  `BLT_ASSERT_IMPL(a_divider_parked, state == S_IDLE, div_cnt == '0)
  `BLT_ASSERT_IMPL(a_report_loads_percent, o_valid && o_report,
                   o_shown_pct == o_smoothed)

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the battery level tracker: directed table, then random phases.
module tb_top;
  import blt_pkg::*;

  localparam int ADC_W           = ADC_BITS_DEF;
  localparam int FRAC_W          = FRAC_BITS_DEF;
  localparam int COR_W           = ADC_W + 2;
  localparam int NUM_DIRECTED    = 23;
  localparam int NUM_FIXED       = 6;
  localparam int PHASES          = 12;
  localparam int TICKS_PER_PHASE = 154;
  localparam int WAIT_MAX        = 18;
  // Two divider passes plus margin for the output register.
  localparam int SETTLE_CYCLES   = 64;
  localparam int SHOW_MAX        = 40;
  // Slowest legal run is roughly 1900 ticks at a 12 ns clock period.
  localparam longint RUN_LIMIT_NS = 10_000_000;

  typedef struct packed {
    logic             charging;
    logic [ADC_W-1:0] sample;
    logic             priming;
  } tick_t;

  typedef struct packed {
    logic                    report;
    logic                    shown_charging;
    logic [PCT_W-1:0]        shown_percent;
    logic [PCT_W-1:0]        smoothed_percent;
    logic signed [COR_W-1:0] corrected_sample;
  } status_t;

  typedef struct packed {
    logic [ADC_W-1:0] empty_lvl;
    logic [ADC_W-1:0] full_lvl;
    logic [7:0]       divisor;
    logic [PCT_W-1:0] count_lim;
    logic [PCT_W-1:0] jump_lim;
  } levels_t;

  // One directed row: the tick, and an expected status where it is obvious.
  typedef struct packed {
    tick_t   stim;
    logic    typed;
    status_t want;
  } row_t;

  // Rows run on the reset register values; state carries over row to row.
  localparam row_t DIRECTED [NUM_DIRECTED] = '{
    // priming with an empty reading: everything loads zero
    '{'{1'b0, 10'd0,    1'b1}, 1'b1, '{1'b0, 1'b0, 7'd0, 7'd0, 12'sd0}},
    // steady zero: no change, no report
    '{'{1'b0, 10'd0,    1'b0}, 1'b1, '{1'b0, 1'b0, 7'd0, 7'd0, 12'sd0}},
    // charger plugged in at full scale: offset cancels the jump, state change reports
    '{'{1'b1, 10'd1023, 1'b0}, 1'b1, '{1'b1, 1'b1, 7'd0, 7'd0, 12'sd0}},
    // charger removed with no drop: offset clears, state change reports
    '{'{1'b0, 10'd0,    1'b0}, 1'b1, '{1'b1, 1'b0, 7'd0, 7'd0, 12'sd0}},
    // full-scale climb while discharging
    '{'{1'b0, 10'd1023, 1'b0}, 1'b0, '0},
    '{'{1'b0, 10'd1023, 1'b0}, 1'b0, '0},
    '{'{1'b0, 10'd1023, 1'b0}, 1'b0, '0},
    // plug in without a rise: no offset
    '{'{1'b1, 10'd1023, 1'b0}, 1'b0, '0},
    // unplug with a full drop: largest positive offset
    '{'{1'b0, 10'd0,    1'b0}, 1'b0, '0},
    // corrected reading near its top
    '{'{1'b0, 10'd1023, 1'b0}, 1'b0, '0},
    '{'{1'b1, 10'd0,    1'b0}, 1'b0, '0},
    // unplug with no drop from the previous reading: no offset
    '{'{1'b0, 10'd0,    1'b0}, 1'b0, '0},
    // priming mid-run, then priming while charging (no offset recompute)
    '{'{1'b0, 10'd512,  1'b1}, 1'b0, '0},
    '{'{1'b1, 10'd1023, 1'b1}, 1'b0, '0},
    '{'{1'b1, 10'd0,    1'b0}, 1'b0, '0},
    '{'{1'b1, 10'd1023, 1'b0}, 1'b0, '0},
    '{'{1'b0, 10'd1,    1'b0}, 1'b0, '0},
    '{'{1'b0, 10'd1022, 1'b0}, 1'b0, '0},
    '{'{1'b0, 10'd341,  1'b0}, 1'b0, '0},
    '{'{1'b0, 10'd682,  1'b0}, 1'b0, '0},
    '{'{1'b0, 10'd0,    1'b1}, 1'b0, '0},
    '{'{1'b0, 10'd1023, 1'b0}, 1'b0, '0},
    '{'{1'b1, 10'd512,  1'b0}, 1'b0, '0}
  };

  // Register settings of the first phases; later phases draw their own.
  localparam levels_t FIXED_LEVELS [NUM_FIXED] = '{
    '{10'd0,    10'd1023, 8'd4,   7'd10,  7'd1},    // reset values
    '{10'd0,    10'd1,    8'd0,   7'd0,   7'd0},    // narrowest span, zero divisor
    '{10'd1023, 10'd1,    8'd255, 7'd127, 7'd100},  // full below empty, slowest filter
    '{10'd512,  10'd512,  8'd1,   7'd0,   7'd0},    // equal levels, no smoothing
    '{10'd100,  10'd900,  8'd2,   7'd3,   7'd2},
    '{10'd200,  10'd700,  8'd1,   7'd1,   7'd100}
  };

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ADC_W-1:0]   cfg_data;

  blt_in_if  #(.ADC_BITS(ADC_W)) tick_ch ();
  blt_out_if #(.ADC_BITS(ADC_W)) status_ch ();

  battery_level_tracker_top #(
    .ADC_BITS (ADC_W),
    .FRAC_BITS(FRAC_W)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .tick     (tick_ch),
    .status   (status_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Tracker mirror: register copy and tracking state.
  levels_t trk_cfg;
  bit      trk_chg;
  int      trk_pct;
  int      trk_last;
  int      trk_ofs;
  int      trk_filt;
  bit      trk_first;
  int      trk_cnt;

  status_t awaited_status [$];

  // Idle pattern of the current phase: 0 random waits, 1 none, 2 rare bursts.
  int pace;
  int mismatches;
  int ticks_sent;
  int priming_sent;
  int status_checked;
  int reports_seen;
  int settings_loaded;

  function automatic int clip(input int v, input int lo, input int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic int draw_wait();
    case (pace)
      1: return 0;
      2: return ($urandom_range(0, 9) == 0) ? int'($urandom_range(1, WAIT_MAX)) : 0;
      default: return int'($urandom_range(0, WAIT_MAX));
    endcase
  endfunction

  // Advance the tracker mirror by one tick and return the status it publishes.
  function automatic status_t advance_tracker(input tick_t t);
    status_t r;
    bit      chg;
    int      smp;
    int      fix;
    int      corr;
    int      pct;
    int      tgt;
    int      d;
    int      num;
    int      den;
    int      q;
    int      step;
    int      lim;
    int      mag;
    chg = t.charging;
    smp = int'(t.sample);
    r   = '0;
    // Priming adopts the charger flag, so no offset recompute follows.
    if (t.priming) trk_chg = chg;
    // Charger flipped: re-derive the offset so the reading stays continuous.
    if (chg != trk_chg) begin
      fix = 0;
      if (!chg && smp < trk_last) fix = trk_last - smp;
      if (chg && smp > trk_last) fix = trk_last - smp;
      trk_ofs = clip(fix, -(1 << ADC_W), (1 << ADC_W) - 1);
    end
    corr     = clip(smp + trk_ofs, -(1 << ADC_W), (1 << (ADC_W + 1)) - 1);
    trk_last = corr;
    // Scale to a truncated percent; with full not above empty this is a step.
    if (corr <= int'(trk_cfg.empty_lvl)) pct = 0;
    else if (corr >= int'(trk_cfg.full_lvl)) pct = 100;
    else pct = 100 * (corr - int'(trk_cfg.empty_lvl)) /
               (int'(trk_cfg.full_lvl) - int'(trk_cfg.empty_lvl));
    // First-order filter, first sample loads; step rounds half toward +inf.
    tgt = pct << FRAC_W;
    if (trk_first) begin
      trk_filt  = tgt;
      trk_first = 1'b0;
    end else begin
      d   = (trk_cfg.divisor == 0) ? 1 : int'(trk_cfg.divisor);
      num = 2 * (tgt - trk_filt) + d;
      den = 2 * d;
      q   = (num >= 0) ? num / den : -((-num + den - 1) / den);
      trk_filt += q;
    end
    pct = (trk_filt + (1 << (FRAC_W - 1))) >>> FRAC_W;

    if (t.priming) begin
      trk_pct = pct;
    end else begin
      lim  = int'(trk_cfg.count_lim);
      step = 0;
      if (pct > trk_pct) begin
        step = pct - trk_pct;
        trk_cnt += step;
      end else if (pct < trk_pct) begin
        step = trk_pct - pct;
        trk_cnt -= step;
      end else begin
        trk_cnt = 0;
      end
      trk_cnt = clip(trk_cnt, -256, 255);
      mag = (trk_cnt < 0) ? -trk_cnt : trk_cnt;
      if (chg != trk_chg ||
          (mag > lim && step > int'(trk_cfg.jump_lim)) ||
          (trk_chg && pct > trk_pct && trk_cnt > lim) ||
          (!trk_chg && pct < trk_pct && -trk_cnt > lim)) begin
        trk_cnt  = 0;
        mag      = 0;
        trk_chg  = chg;
        trk_pct  = pct;
        r.report = 1'b1;
      end
      // Drift without a report: nudge the offset one step toward zero.
      if (mag > lim) begin
        if (trk_cnt > 0 && trk_ofs > 0) trk_ofs--;
        else if (trk_cnt < 0 && trk_ofs < 0) trk_ofs++;
        trk_cnt = 0;
      end
    end
    r.shown_charging   = trk_chg;
    r.shown_percent    = PCT_W'(trk_pct);
    r.smoothed_percent = PCT_W'(pct);
    r.corrected_sample = COR_W'(corr);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= SHOW_MAX) $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [COR_W-1:0] got,
                             input logic [COR_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("status #%0d %s: got %0d, want %0d",
                                status_checked, name, got, want));
  endtask

  // Offer one tick after a drawn gap and hold it until accepted.
  task automatic drive_tick(input tick_t t, input logic typed, input status_t want);
    int      gap;
    status_t predicted;
    gap = draw_wait();
    if (gap > 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_ch.valid    <= 1'b1;
    tick_ch.charging <= t.charging;
    tick_ch.sample   <= t.sample;
    tick_ch.priming  <= t.priming;
    do @(posedge clk); while (!tick_ch.ready);
    predicted = advance_tracker(t);
    awaited_status.push_back(typed ? want : predicted);
    ticks_sent++;
    if (t.priming) priming_sent++;
  endtask

  // Drop valid and wait until every awaited status transaction has drained.
  task automatic drain_ticks();
    tick_ch.valid <= 1'b0;
    while (awaited_status.size() != 0) @(posedge clk);
  endtask

  // Write all five registers on consecutive edges; the block is idle here.
  task automatic load_levels(input levels_t s);
    cfg_we    <= 1'b1;
    cfg_index <= REG_EMPTY_LEVEL;
    cfg_data  <= s.empty_lvl;
    @(posedge clk);
    cfg_index <= REG_FULL_LEVEL;
    cfg_data  <= s.full_lvl;
    @(posedge clk);
    cfg_index <= REG_SMOOTHING;
    cfg_data  <= ADC_W'(s.divisor);
    @(posedge clk);
    cfg_index <= REG_COUNT_LIMIT;
    cfg_data  <= ADC_W'(s.count_lim);
    @(posedge clk);
    cfg_index <= REG_JUMP_LIMIT;
    cfg_data  <= ADC_W'(s.jump_lim);
    @(posedge clk);
    cfg_we  <= 1'b0;
    trk_cfg = s;
    settings_loaded++;
  endtask

  // Status sink: stall at random, check each accepted transaction in order.
  initial begin : status_sink
    int      stall;
    status_t got;
    status_t want;
    status_ch.ready = 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        status_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      status_ch.ready <= 1'b1;
      do @(posedge clk); while (status_ch.valid !== 1'b1);
      got = '{status_ch.report, status_ch.shown_charging, status_ch.shown_percent,
              status_ch.smoothed_percent, status_ch.corrected_sample};
      if (awaited_status.size() == 0) begin
        report_mismatch($sformatf("status transaction with nothing awaited (percent %0d)",
                                  got.smoothed_percent));
      end else begin
        want = awaited_status.pop_front();
        check_field("report", COR_W'(got.report), COR_W'(want.report));
        check_field("shown_charging", COR_W'(got.shown_charging),
                    COR_W'(want.shown_charging));
        check_field("shown_percent", COR_W'(got.shown_percent), COR_W'(want.shown_percent));
        check_field("smoothed_percent", COR_W'(got.smoothed_percent),
                    COR_W'(want.smoothed_percent));
        check_field("corrected_sample", got.corrected_sample, want.corrected_sample);
        status_checked++;
        if (got.report === 1'b1) reports_seen++;
      end
    end
  end

  initial begin : stimulus
    tick_t   t;
    levels_t s;
    int      drift;
    bit      chg_now;
    int      pick;
    int      lvl;
    // Hold everything known and in reset; mirror the reset state.
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = REG_EMPTY_LEVEL;
    cfg_data         = '0;
    tick_ch.valid    = 1'b0;
    tick_ch.charging = 1'b0;
    tick_ch.sample   = '0;
    tick_ch.priming  = 1'b0;
    trk_cfg   = '{'0, {ADC_W{1'b1}}, SMOOTHING_RST, COUNT_LIMIT_RST, JUMP_LIMIT_RST};
    trk_chg   = 1'b0;
    trk_pct   = 0;
    trk_last  = 0;
    trk_ofs   = 0;
    trk_filt  = 0;
    trk_first = 1'b1;
    trk_cnt   = 0;
    pace      = 0;
    mismatches      = 0;
    ticks_sent      = 0;
    priming_sent    = 0;
    status_checked  = 0;
    reports_seen    = 0;
    settings_loaded = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed rows on the reset register values.
    foreach (DIRECTED[i]) drive_tick(DIRECTED[i].stim, DIRECTED[i].typed, DIRECTED[i].want);
    drain_ticks();

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase < NUM_FIXED) begin
        s = FIXED_LEVELS[phase];
      end else begin
        s.empty_lvl = ADC_W'($urandom_range(0, 900));
        s.full_lvl  = ADC_W'($urandom_range(int'(s.empty_lvl) + 1, 1023));
        s.divisor   = 8'($urandom_range(1, 16));
        s.count_lim = PCT_W'($urandom_range(0, 40));
        s.jump_lim  = PCT_W'($urandom_range(0, 20));
      end
      pace = phase % 3;
      load_levels(s);
      drift   = int'($urandom_range(0, 1023));
      chg_now = 1'($urandom_range(0, 1));
      for (int k = 0; k < TICKS_PER_PHASE; k++) begin
        pick = int'($urandom_range(0, 99));
        if (pick < 3) begin
          // Stray priming tick with random content.
          t = '{1'($urandom_range(0, 1)), ADC_W'($urandom), 1'b1};
        end else if (pick < 75) begin
          // Battery behavior: drift down on battery, up on the charger.
          if ($urandom_range(0, 29) == 0) chg_now = !chg_now;
          drift = clip(drift + int'($urandom_range(0, 24)) - (chg_now ? 8 : 16), 0, 1023);
          t = '{chg_now, ADC_W'(drift), 1'b0};
        end else if (pick < 90) begin
          t = '{1'($urandom_range(0, 1)), ADC_W'($urandom), 1'b0};
        end else begin
          // Readings at and next to the scale edges.
          case ($urandom_range(0, 5))
            0: lvl = 0;
            1: lvl = 1023;
            2: lvl = int'(s.empty_lvl);
            3: lvl = int'(s.full_lvl);
            4: lvl = clip(int'(s.empty_lvl) + 1, 0, 1023);
            default: lvl = clip(int'(s.full_lvl) - 1, 0, 1023);
          endcase
          t = '{chg_now, ADC_W'(lvl), 1'b0};
        end
        drive_tick(t, 1'b0, '0);
      end
      drain_ticks();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d ticks (%0d priming) under %0d register settings after the reset values.",
             ticks_sent, priming_sent, settings_loaded);
    $display("Checked %0d status transactions, %0d of them publishing a new state.",
             status_checked, reports_seen);
    if (mismatches == 0 && awaited_status.size() == 0) begin
      $display("battery_level_tracker_top verification clean");
    end else begin
      $display("battery_level_tracker_top verification failed");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("Timeout with %0d status transactions still awaited.", awaited_status.size());
    $display("battery_level_tracker_top verification failed");
    $finish;
  end

endmodule
